// ----- hw/rtl/avs_pkg.sv -----
// shared constants, codes and command types for the age-structured sir day stepper
// no dependencies
package avs_pkg;

  localparam int FRAC_BITS = 31;
  localparam int RATE_BITS = 28;
  localparam int AGES      = 3;
  localparam int DAYS_DEF  = 7;

  localparam logic [31:0] ONE = 32'h8000_0000;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_DAY   = 2'd2;

  localparam logic [2:0] CFG_BETA  = 3'd0;
  localparam logic [2:0] CFG_GAMMA = 3'd1;
  localparam logic [2:0] CFG_SPRD  = 3'd2;
  localparam logic [2:0] CFG_INFW  = 3'd3;
  localparam logic [2:0] CFG_ILLW  = 3'd4;
  localparam logic [2:0] CFG_VDAY  = 3'd5;
  localparam logic [2:0] CFG_COV   = 3'd6;
  localparam logic [2:0] CFG_OBS   = 3'd7;

  // multiply steps of one day
  localparam logic [3:0] U_EFF = 4'd0;
  localparam logic [3:0] U_CON = 4'd1;
  localparam logic [3:0] U_LAM = 4'd2;
  localparam logic [3:0] U_NU  = 4'd3;
  localparam logic [3:0] U_WL  = 4'd4;
  localparam logic [3:0] U_NV  = 4'd5;
  localparam logic [3:0] U_RP  = 4'd6;
  localparam logic [3:0] U_RV  = 4'd7;
  localparam logic [3:0] U_IL  = 4'd8;
  localparam logic [3:0] U_VAC = 4'd9;

  typedef struct packed {
    logic       accept;
    logic       phase;
    logic       wb;
    logic [3:0] uop;
    logic [1:0] age;
    logic [1:0] col;
    logic       finish;
  } avs_cmd_t;

  typedef struct packed {
    logic vac_now;
  } avs_stat_t;

endpackage

// ----- hw/rtl/avs_in_if.sv -----
// input item channel: operation and its operands
// no dependencies
interface avs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [1:0]  matrix_row;
  logic [1:0]  matrix_column;
  logic [31:0] matrix_value;
  logic [31:0] start_susceptible;
  logic [31:0] start_infectious;

  modport source(output valid, operation, matrix_row, matrix_column, matrix_value,
                 start_susceptible, start_infectious, input ready);
  modport sink(input valid, operation, matrix_row, matrix_column, matrix_value,
               start_susceptible, start_infectious, output ready);
endinterface

// ----- hw/rtl/avs_out_if.sv -----
// result item channel: daily incidence, weekly sums, flags and attack rates
// no dependencies
interface avs_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        daily_young;
  logic [31:0]        daily_adult;
  logic [31:0]        daily_elderly;
  logic [33:0]        week_young;
  logic [33:0]        week_adult;
  logic [33:0]        week_elderly;
  logic               week_done;
  logic               week_recorded;
  logic signed [32:0] attack_young;
  logic signed [32:0] attack_adult;
  logic signed [32:0] attack_elderly;

  modport source(output valid, daily_young, daily_adult, daily_elderly, week_young,
                 week_adult, week_elderly, week_done, week_recorded, attack_young,
                 attack_adult, attack_elderly, input ready);
  modport sink(input valid, daily_young, daily_adult, daily_elderly, week_young,
               week_adult, week_elderly, week_done, week_recorded, attack_young,
               attack_adult, attack_elderly, output ready);
endinterface

// ----- hw/rtl/avs_cfg_if.sv -----
// configuration write channel: register index and data
// no dependencies
interface avs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- hw/rtl/avs_ctrl.sv -----
// controller: sequences the multiply steps of a day and the result handoff
// depends on avs_pkg
module avs_ctrl import avs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic [1:0] in_op,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  output avs_cmd_t  cmd,
  input  avs_stat_t stat
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] LAST   = 2'(AGES - 1);

  logic [1:0] state_r, state_nxt;
  logic [3:0] uop_r, uop_nxt;
  logic [1:0] age_r, age_nxt;
  logic [1:0] col_r, col_nxt;
  logic       ph_r, ph_nxt;
  logic       oval_r, oval_nxt;

  always_comb begin
    state_nxt = state_r;
    uop_nxt   = uop_r;
    age_nxt   = age_r;
    col_nxt   = col_r;
    ph_nxt    = ph_r;
    cmd       = '0;
    cmd.uop   = uop_r;
    cmd.age   = age_r;
    cmd.col   = col_r;
    cmd.phase = ph_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_op == OP_DAY) begin
            state_nxt = S_MUL;
            uop_nxt   = U_EFF;
            age_nxt   = '0;
            col_nxt   = '0;
            ph_nxt    = 1'b0;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_MUL: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          cmd.wb = 1'b1;
          case (uop_r)
            U_EFF: begin
              if (age_r == LAST) begin
                uop_nxt = U_CON;
                age_nxt = '0;
              end else begin
                age_nxt = age_r + 2'd1;
              end
            end
            U_CON: begin
              if (col_r == LAST) begin
                col_nxt = '0;
                if (age_r == LAST) begin
                  uop_nxt = U_LAM;
                  age_nxt = '0;
                end else begin
                  age_nxt = age_r + 2'd1;
                end
              end else begin
                col_nxt = col_r + 2'd1;
              end
            end
            U_LAM: begin
              if (age_r == LAST) begin
                uop_nxt = U_NU;
                age_nxt = '0;
              end else begin
                age_nxt = age_r + 2'd1;
              end
            end
            U_NU: uop_nxt = U_WL;
            U_WL: uop_nxt = U_NV;
            U_NV: uop_nxt = U_RP;
            U_RP: uop_nxt = U_RV;
            U_RV: uop_nxt = U_IL;
            U_IL: begin
              if (age_r == LAST) begin
                if (stat.vac_now) begin
                  uop_nxt = U_VAC;
                end else begin
                  state_nxt = S_FIN;
                end
              end else begin
                age_nxt = age_r + 2'd1;
                uop_nxt = U_NU;
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_FIN: begin
        if (!oval_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign oval_nxt  = cmd.finish | (oval_r & ~out_ready);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = oval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      uop_r   <= U_EFF;
      age_r   <= '0;
      col_r   <= '0;
      ph_r    <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      uop_r   <= uop_nxt;
      age_r   <= age_nxt;
      col_r   <= col_nxt;
      ph_r    <= ph_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule

// ----- hw/rtl/avs_dp.sv -----
// datapath: config registers, contact table, compartments, shared multiplier, result register
// depends on avs_pkg
module avs_dp import avs_pkg::*; #(
  parameter int DAYS_PER_WEEK = DAYS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  avs_cmd_t           cmd,
  output avs_stat_t          stat,
  input  logic [1:0]         in_op,
  input  logic [1:0]         in_row,
  input  logic [1:0]         in_col,
  input  logic [31:0]        in_mval,
  input  logic [31:0]        in_s0,
  input  logic [31:0]        in_i0,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [31:0]        cfg_data,
  output logic [31:0]        daily [AGES],
  output logic [33:0]        week [AGES],
  output logic               week_done,
  output logic               week_rec,
  output logic signed [32:0] attack [AGES]
);

  localparam int DMW = (DAYS_PER_WEEK > 1) ? $clog2(DAYS_PER_WEEK) : 1;
  localparam logic [DMW-1:0] DLAST = DMW'(DAYS_PER_WEEK - 1);
  localparam logic [1:0] ELD = 2'(AGES - 1);
  localparam logic signed [33:0] POS1 = 34'sh0_8000_0000;
  localparam logic signed [33:0] NEG1 = -34'sh0_8000_0000;

  function automatic logic [31:0] cap_one(input logic [33:0] v);
    cap_one = (v > {2'b0, ONE}) ? ONE : v[31:0];
  endfunction

  // configuration
  logic [31:0] beta_r, gamma_r, sprd_r, infw_r, illw_r, cov_r;
  logic [15:0] vday_r;
  logic [7:0]  obs_r;

  // state
  logic [31:0] contact_r [AGES*AGES];
  logic [31:0] sp_r [AGES];
  logic [31:0] ip_r [AGES];
  logic [31:0] sv_r [AGES];
  logic [31:0] iv_r [AGES];
  logic [33:0] ws_r [AGES];
  logic [31:0] start_r;
  logic [15:0] day_r;
  logic [7:0]  wk_r;
  logic [DMW-1:0] dmod_r;
  logic        dayop_r;

  // day scratch
  logic [35:0] eff_r [AGES];
  logic [39:0] s_r [AGES];
  logic [47:0] lam_r [AGES];
  logic [47:0] wl_r;
  logic [31:0] nu_r, nv_r, rp_r, rv_r;
  logic [31:0] dly_r [AGES];
  logic [55:0] acc_r;

  // result register
  logic [31:0]        o_daily_r [AGES];
  logic [33:0]        o_week_r [AGES];
  logic               o_done_r, o_rec_r;
  logic signed [32:0] o_att_r [AGES];

  logic [3:0]  cidx, lidx;
  logic [47:0] opa;
  logic [31:0] opb;
  logic        rate_sh;
  logic [23:0] half;
  logic [55:0] pm;
  logic [79:0] full;
  logic [47:0] res;
  logic [31:0] f, ip_new, iv_new, mv, sv2_new, cap_sp, cap_sv;
  logic [33:0] f_sum;
  logic [32:0] ipt, ivt, svsum;
  logic [15:0] day_n;
  logic [DMW-1:0] dmod_n;
  logic        wdone;
  logic signed [32:0] att [AGES];

  assign cidx = ({2'b0, cmd.age} << 1) + {2'b0, cmd.age} + {2'b0, cmd.col};
  assign lidx = ({2'b0, in_row} << 1) + {2'b0, in_row} + {2'b0, in_col};

  always_comb begin
    opa     = '0;
    opb     = '0;
    rate_sh = 1'b0;
    case (cmd.uop)
      U_EFF: begin opa = {16'b0, iv_r[cmd.age]}; opb = sprd_r; end
      U_CON: begin opa = {12'b0, eff_r[cmd.col]}; opb = contact_r[cidx]; end
      U_LAM: begin opa = {8'b0, s_r[cmd.age]}; opb = beta_r; rate_sh = 1'b1; end
      U_NU:  begin opa = lam_r[cmd.age]; opb = sp_r[cmd.age]; end
      U_WL:  begin opa = lam_r[cmd.age]; opb = infw_r; end
      U_NV:  begin opa = wl_r; opb = sv_r[cmd.age]; end
      U_RP:  begin opa = {16'b0, ip_r[cmd.age]}; opb = gamma_r; end
      U_RV:  begin opa = {16'b0, iv_r[cmd.age]}; opb = gamma_r; end
      U_IL:  begin opa = {16'b0, nv_r}; opb = illw_r; end
      U_VAC: begin opa = {16'b0, sp_r[ELD]}; opb = cov_r; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  // low half of the wide operand on phase 0, high half on phase 1
  assign half = cmd.phase ? opa[47:24] : opa[23:0];
  assign pm   = half * opb;
  assign full = {pm, 24'b0} + {24'b0, acc_r};
  assign res  = rate_sh ? full[RATE_BITS +: 48] : full[FRAC_BITS +: 48];

  always_comb begin
    cap_sp  = (res > {16'b0, sp_r[cmd.age]}) ? sp_r[cmd.age] : res[31:0];
    cap_sv  = (res > {16'b0, sv_r[cmd.age]}) ? sv_r[cmd.age] : res[31:0];
    f_sum   = {2'b0, nu_r} + {1'b0, res[32:0]};
    f       = cap_one(f_sum);
    ipt     = {1'b0, ip_r[cmd.age]} + {1'b0, nu_r};
    ivt     = {1'b0, iv_r[cmd.age]} + {1'b0, nv_r};
    ip_new  = (ipt < {1'b0, rp_r}) ? 32'd0 : cap_one({1'b0, ipt - {1'b0, rp_r}});
    iv_new  = (ivt < {1'b0, rv_r}) ? 32'd0 : cap_one({1'b0, ivt - {1'b0, rv_r}});
    mv      = (res > {16'b0, sp_r[ELD]}) ? sp_r[ELD] : res[31:0];
    svsum   = {1'b0, sv_r[ELD]} + {1'b0, mv};
    sv2_new = cap_one({1'b0, svsum});
    day_n   = day_r + 16'd1;
    // a wrap of the day counter lands on a week boundary
    if (day_n == 16'd0 || dmod_r == DLAST) begin
      dmod_n = '0;
    end else begin
      dmod_n = dmod_r + DMW'(1);
    end
    wdone = (dmod_n == '0);
  end

  assign stat.vac_now = (vday_r != 16'd0) && (day_n == vday_r);

  for (genvar a = 0; a < AGES; a++) begin : g_att
    logic signed [33:0] diff;
    assign diff = $signed({2'b0, start_r})
                - $signed({1'b0, {1'b0, sp_r[a]} + {1'b0, sv_r[a]}});
    assign att[a] = (diff > POS1) ? POS1[32:0] : (diff < NEG1) ? NEG1[32:0] : diff[32:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_op == OP_LOAD && in_row < 2'(AGES) && in_col < 2'(AGES)) begin
      contact_r[lidx] <= in_mval;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd.phase) begin
      acc_r <= pm;
    end
    if (cmd.wb) begin
      case (cmd.uop)
        U_EFF: eff_r[cmd.age] <= {4'b0, ip_r[cmd.age]} + res[35:0];
        U_LAM: lam_r[cmd.age] <= res;
        U_NU:  nu_r <= cap_sp;
        U_WL:  wl_r <= res;
        U_NV:  nv_r <= cap_sv;
        U_RP:  rp_r <= res[31:0];
        U_RV:  rv_r <= res[31:0];
        U_IL:  dly_r[cmd.age] <= f;
        default: ;
      endcase
    end
    for (int a = 0; a < AGES; a++) begin
      if (cmd.accept) begin
        s_r[a] <= '0;
      end else if (cmd.wb && cmd.uop == U_CON && cmd.age == 2'(a)) begin
        s_r[a] <= s_r[a] + {4'b0, res[35:0]};
      end
    end
    if (cmd.finish) begin
      for (int a = 0; a < AGES; a++) begin
        o_daily_r[a] <= dayop_r ? dly_r[a] : 32'd0;
        o_week_r[a]  <= (dayop_r && wdone) ? ws_r[a] : 34'd0;
        o_att_r[a]   <= att[a];
      end
      o_done_r <= dayop_r && wdone;
      o_rec_r  <= dayop_r && wdone && (wk_r < obs_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r  <= '0;
      gamma_r <= '0;
      sprd_r  <= ONE;
      infw_r  <= ONE;
      illw_r  <= ONE;
      vday_r  <= '0;
      cov_r   <= '0;
      obs_r   <= 8'd53;
      for (int a = 0; a < AGES; a++) begin
        sp_r[a] <= '0;
        ip_r[a] <= '0;
        sv_r[a] <= '0;
        iv_r[a] <= '0;
        ws_r[a] <= '0;
      end
      start_r <= '0;
      day_r   <= '0;
      wk_r    <= '0;
      dmod_r  <= '0;
      dayop_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_BETA:  beta_r  <= cfg_data;
          CFG_GAMMA: gamma_r <= cfg_data;
          CFG_SPRD:  sprd_r  <= cfg_data;
          CFG_INFW:  infw_r  <= cfg_data;
          CFG_ILLW:  illw_r  <= cfg_data;
          CFG_VDAY:  vday_r  <= cfg_data[15:0];
          CFG_COV:   cov_r   <= cfg_data;
          CFG_OBS:   obs_r   <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        dayop_r <= (in_op == OP_DAY);
        if (in_op == OP_START) begin
          for (int a = 0; a < AGES; a++) begin
            sp_r[a] <= cap_one({2'b0, in_s0});
            ip_r[a] <= cap_one({2'b0, in_i0});
            sv_r[a] <= '0;
            iv_r[a] <= '0;
            ws_r[a] <= '0;
          end
          start_r <= cap_one({2'b0, in_s0});
          day_r   <= '0;
          wk_r    <= '0;
          dmod_r  <= '0;
        end
      end
      if (cmd.wb && cmd.uop == U_IL) begin
        sp_r[cmd.age] <= sp_r[cmd.age] - nu_r;
        sv_r[cmd.age] <= sv_r[cmd.age] - nv_r;
        ip_r[cmd.age] <= ip_new;
        iv_r[cmd.age] <= iv_new;
        ws_r[cmd.age] <= ws_r[cmd.age] + {2'b0, f};
      end
      if (cmd.wb && cmd.uop == U_VAC) begin
        sp_r[ELD] <= sp_r[ELD] - mv;
        sv_r[ELD] <= sv2_new;
      end
      if (cmd.finish && dayop_r) begin
        day_r  <= day_n;
        dmod_r <= dmod_n;
        if (wdone) begin
          for (int a = 0; a < AGES; a++) begin
            ws_r[a] <= '0;
          end
          if (wk_r != 8'hFF) begin
            wk_r <= wk_r + 8'd1;
          end
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < AGES; a++) begin
      daily[a]  = o_daily_r[a];
      week[a]   = o_week_r[a];
      attack[a] = o_att_r[a];
    end
  end
  assign week_done = o_done_r;
  assign week_rec  = o_rec_r;

endmodule

// ----- hw/rtl/age_vaccine_sir_euler_step.sv -----
// age-structured sir day stepper, top level: load and start items go from accept to
// handoff; a day item runs 33 products (34 on the vaccination day) through one
// shared 24x32 multiplier, low half then high half, between accept and handoff.
// one item at a time; the next item is taken while a result waits in the output register.
// synchronous active-low reset: config to defaults, compartments and counters to zero;
// the contact table holds no reset value and must be loaded.
module age_vaccine_sir_euler_step import avs_pkg::*; #(
  parameter int DAYS_PER_WEEK = DAYS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  avs_in_if.sink     in_ch,
  avs_out_if.source  out_ch,
  avs_cfg_if.sink    cfg_ch
);

  avs_cmd_t           cmd;
  avs_stat_t          stat;
  logic [31:0]        daily [AGES];
  logic [33:0]        week [AGES];
  logic signed [32:0] attack [AGES];

  assign cfg_ch.ready = 1'b1;

  avs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.operation),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  avs_dp #(.DAYS_PER_WEEK(DAYS_PER_WEEK)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_op     (in_ch.operation),
    .in_row    (in_ch.matrix_row),
    .in_col    (in_ch.matrix_column),
    .in_mval   (in_ch.matrix_value),
    .in_s0     (in_ch.start_susceptible),
    .in_i0     (in_ch.start_infectious),
    .cfg_we    (cfg_ch.valid),
    .cfg_idx   (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .daily     (daily),
    .week      (week),
    .week_done (out_ch.week_done),
    .week_rec  (out_ch.week_recorded),
    .attack    (attack)
  );

  assign out_ch.daily_young    = daily[0];
  assign out_ch.daily_adult    = daily[1];
  assign out_ch.daily_elderly  = daily[2];
  assign out_ch.week_young     = week[0];
  assign out_ch.week_adult     = week[1];
  assign out_ch.week_elderly   = week[2];
  assign out_ch.attack_young   = attack[0];
  assign out_ch.attack_adult   = attack[1];
  assign out_ch.attack_elderly = attack[2];

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("item taken while another is in progress");

  a_rec_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.week_done |-> !out_ch.week_recorded)
    else $error("week recorded without a closed week");

  a_week_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.week_done |->
      out_ch.week_young == 34'd0 && out_ch.week_adult == 34'd0 &&
      out_ch.week_elderly == 34'd0)
    else $error("week sums shown outside a week close");
`endif

endmodule

// ----- verif/avs_report_checker.sv -----
// watches the input, result and config channels of the sir day stepper and predicts each report
// depends on avs_pkg and the avs_in_if, avs_out_if and avs_cfg_if interfaces
module avs_report_checker import avs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  avs_in_if        in_mon,
  avs_out_if       out_mon,
  avs_cfg_if       cfg_mon,
  output int       fail_count,
  output int       backlog
);

  localparam int WEEK_DAYS = DAYS_DEF;
  localparam logic [63:0] UNIT = 64'h8000_0000;

  typedef struct packed {
    logic [2:0][31:0]        daily;
    logic [2:0][33:0]        week;
    logic                    done;
    logic                    recorded;
    logic [2:0][32:0]        attack;
  } report_t;

  report_t expected_reports[$];

  // configuration copy
  logic [63:0] beta, gamma, w_spread, w_infect, w_ill, vac_day, coverage, obs_weeks;
  // epidemic state copy
  logic [63:0] contact[9];
  logic [63:0] s_plain[3], i_plain[3], s_prot[3], i_prot[3], wk_acc[3];
  logic [63:0] start_level, day_cnt, week_cnt;

  function automatic logic [63:0] mulsh(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sh;
    if (p[127:64] != 0) return '1;
    return p[63:0];
  endfunction

  function automatic logic [63:0] cap(logic [63:0] v, logic [63:0] lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic void fill_attack(ref report_t r);
    logic signed [63:0] att;
    for (int a = 0; a < 3; a++) begin
      att = $signed(start_level) - $signed(s_plain[a] + s_prot[a]);
      if (att > $signed(UNIT)) att = $signed(UNIT);
      if (att < -$signed(UNIT)) att = -$signed(UNIT);
      r.attack[a] = att[32:0];
    end
  endfunction

  function automatic report_t epi_predict(logic [1:0] op, logic [1:0] row, logic [1:0] col,
                                          logic [31:0] mval, logic [31:0] s_in,
                                          logic [31:0] i_in);
    report_t r;
    logic [63:0] lam[3], eff[3];
    logic [63:0] acc, sp, sv, ip, iv, nu, nv, rp, rv, f, mv;
    r = '0;
    if (op == OP_LOAD) begin
      if (row < 3 && col < 3) contact[row * 3 + col] = {32'd0, mval};
    end else if (op == OP_START) begin
      sp = cap({32'd0, s_in}, UNIT);
      ip = cap({32'd0, i_in}, UNIT);
      for (int a = 0; a < 3; a++) begin
        s_plain[a] = sp;
        i_plain[a] = ip;
        s_prot[a]  = 0;
        i_prot[a]  = 0;
        wk_acc[a]  = 0;
      end
      start_level = sp;
      day_cnt = 0;
      week_cnt = 0;
    end else if (op == OP_DAY) begin
      // force of infection from the state before the step
      for (int j = 0; j < 3; j++) eff[j] = i_plain[j] + mulsh(w_spread, i_prot[j], FRAC_BITS);
      for (int a = 0; a < 3; a++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += mulsh(contact[a * 3 + j], eff[j], FRAC_BITS);
        lam[a] = mulsh(beta, acc, RATE_BITS);
      end
      day_cnt = (day_cnt + 1) & 64'hFFFF;
      for (int a = 0; a < 3; a++) begin
        sp = s_plain[a]; sv = s_prot[a]; ip = i_plain[a]; iv = i_prot[a];
        nu = cap(mulsh(lam[a], sp, FRAC_BITS), sp);
        nv = cap(mulsh(mulsh(w_infect, lam[a], FRAC_BITS), sv, FRAC_BITS), sv);
        rp = mulsh(gamma, ip, FRAC_BITS);
        rv = mulsh(gamma, iv, FRAC_BITS);
        s_plain[a] = sp - nu;
        s_prot[a]  = sv - nv;
        i_plain[a] = (ip + nu < rp) ? 64'd0 : cap(ip + nu - rp, UNIT);
        i_prot[a]  = (iv + nv < rv) ? 64'd0 : cap(iv + nv - rv, UNIT);
        f = cap(nu + mulsh(w_ill, nv, FRAC_BITS), UNIT);
        wk_acc[a] += f;
        r.daily[a] = f[31:0];
      end
      if (vac_day != 0 && day_cnt == vac_day) begin
        mv = cap(mulsh(coverage, s_plain[2], FRAC_BITS), s_plain[2]);
        s_plain[2] -= mv;
        s_prot[2]  += mv;
      end
      for (int a = 0; a < 3; a++) begin
        s_plain[a] = cap(s_plain[a], UNIT);
        s_prot[a]  = cap(s_prot[a], UNIT);
      end
      if ((day_cnt % WEEK_DAYS) == 0) begin
        for (int a = 0; a < 3; a++) begin
          r.week[a] = wk_acc[a][33:0];
          wk_acc[a] = 0;
        end
        r.done = 1'b1;
        r.recorded = (week_cnt < obs_weeks);
        if (week_cnt < 255) week_cnt++;
      end
    end
    fill_attack(r);
    return r;
  endfunction

  function automatic void cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch %s: expected %h got %h", name, exp_v, act_v);
    end
  endfunction

  assign backlog = expected_reports.size();

  always @(posedge clk) begin
    report_t e;
    if (!rst_n) begin
      beta <= 0; gamma <= 0; w_spread <= UNIT; w_infect <= UNIT; w_ill <= UNIT;
      vac_day <= 0; coverage <= 0; obs_weeks <= 53;
      for (int a = 0; a < 3; a++) begin
        s_plain[a] <= 0; i_plain[a] <= 0; s_prot[a] <= 0; i_prot[a] <= 0; wk_acc[a] <= 0;
      end
      for (int k = 0; k < 9; k++) contact[k] <= 0;
      start_level <= 0; day_cnt <= 0; week_cnt <= 0;
      expected_reports.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_BETA:  beta      <= {32'd0, cfg_mon.data};
          CFG_GAMMA: gamma     <= {32'd0, cfg_mon.data};
          CFG_SPRD:  w_spread  <= {32'd0, cfg_mon.data};
          CFG_INFW:  w_infect  <= {32'd0, cfg_mon.data};
          CFG_ILLW:  w_ill     <= {32'd0, cfg_mon.data};
          CFG_VDAY:  vac_day   <= {48'd0, cfg_mon.data[15:0]};
          CFG_COV:   coverage  <= {32'd0, cfg_mon.data};
          CFG_OBS:   obs_weeks <= {56'd0, cfg_mon.data[7:0]};
          default: ;
        endcase
      end
      // state is updated by blocking writes inside the predictor
      if (in_mon.valid && in_mon.ready)
        expected_reports.push_back(epi_predict(in_mon.operation, in_mon.matrix_row,
                                               in_mon.matrix_column, in_mon.matrix_value,
                                               in_mon.start_susceptible,
                                               in_mon.start_infectious));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("mismatch: report with no item waiting");
        end else begin
          e = expected_reports.pop_front();
          cmp_field("daily_young",    e.daily[0], out_mon.daily_young);
          cmp_field("daily_adult",    e.daily[1], out_mon.daily_adult);
          cmp_field("daily_elderly",  e.daily[2], out_mon.daily_elderly);
          cmp_field("week_young",     e.week[0], out_mon.week_young);
          cmp_field("week_adult",     e.week[1], out_mon.week_adult);
          cmp_field("week_elderly",   e.week[2], out_mon.week_elderly);
          cmp_field("week_done",      e.done, out_mon.week_done);
          cmp_field("week_recorded",  e.recorded, out_mon.week_recorded);
          cmp_field("attack_young",   e.attack[0], out_mon.attack_young);
          cmp_field("attack_adult",   e.attack[1], out_mon.attack_adult);
          cmp_field("attack_elderly", e.attack[2], out_mon.attack_elderly);
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

// ----- verif/tb_age_vaccine_sir_euler_step.sv -----
// testbench top for the sir day stepper: clock, reset, config phases, items and verdict
// depends on avs_pkg, the channel interfaces, avs_report_checker and the block itself
module tb_age_vaccine_sir_euler_step;
  import avs_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE = 100;
  localparam int PHASE_ITEMS = 200;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   backlog;
  int   cycles;
  bit   steady;

  avs_in_if  in_ch();
  avs_out_if out_ch();
  avs_cfg_if cfg_ch();

  age_vaccine_sir_euler_step i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  avs_report_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .backlog(backlog)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 12);
  endfunction

  // result side stalls
  initial begin
    int gap;
    out_ch.ready <= 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_item(logic [1:0] op, logic [1:0] row, logic [1:0] col,
                           logic [31:0] mval, logic [31:0] s0, logic [31:0] i0);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.operation         <= op;
    in_ch.matrix_row        <= row;
    in_ch.matrix_column     <= col;
    in_ch.matrix_value      <= mval;
    in_ch.start_susceptible <= s0;
    in_ch.start_infectious  <= i0;
    in_ch.valid             <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (backlog != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic write_all(logic [31:0] b, logic [31:0] g, logic [31:0] sw, logic [31:0] iw,
                           logic [31:0] lw, logic [31:0] vd, logic [31:0] cv, logic [31:0] ob);
    write_reg(CFG_BETA, b);
    write_reg(CFG_GAMMA, g);
    write_reg(CFG_SPRD, sw);
    write_reg(CFG_INFW, iw);
    write_reg(CFG_ILLW, lw);
    write_reg(CFG_VDAY, vd);
    write_reg(CFG_COV, cv);
    write_reg(CFG_OBS, ob);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_frac();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return ONE;
      2: return $urandom();
      default: return $urandom_range(0, ONE);
    endcase
  endfunction

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      if ($urandom_range(0, 3) == 0)
        send_item(OP_START, 2'($urandom()), 2'($urandom()), $urandom(), $urandom(),
                  $urandom());
      else
        send_item(OP_START, 2'($urandom()), 2'($urandom()), $urandom(),
                  $urandom_range(ONE / 2, ONE), $urandom_range(0, ONE / 64));
    end else if (pick < 12) begin
      send_item(OP_LOAD, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, ONE / 2),
                $urandom(), $urandom());
    end else if (pick < 14) begin
      send_item(2'd3, 2'($urandom()), 2'($urandom()), $urandom(), $urandom(), $urandom());
    end else begin
      send_item(OP_DAY, 2'($urandom()), 2'($urandom()), $urandom(), $urandom(),
                $urandom());
    end
  endtask

  initial begin
    cycles = 0;
    steady = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OP_LOAD;
    in_ch.matrix_row <= '0;
    in_ch.matrix_column <= '0;
    in_ch.matrix_value <= '0;
    in_ch.start_susceptible <= '0;
    in_ch.start_infectious <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_BETA;
    cfg_ch.data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: the contact table is filled before any day item
    write_all(32'h1000_0000, 32'h1999_999A, ONE / 2, ONE / 4, ONE / 2, 32'd3, ONE, 32'd1);
    for (int k = 0; k < 9; k++)
      send_item(OP_LOAD, 2'(k / 3), 2'(k % 3), (k == 0) ? ONE : (k == 4) ? 32'd0 : ONE / 3,
                '0, '0);
    send_item(OP_LOAD, 2'd3, 2'd1, 32'hFFFF_FFFF, '0, '0);   // ignored row
    send_item(OP_LOAD, 2'd1, 2'd3, 32'hFFFF_FFFF, '0, '0);   // ignored column
    send_item(2'd3, 2'd3, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_START, '0, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // saturating start
    send_item(OP_DAY, '0, '0, '0, '0, '0);
    send_item(OP_START, '0, '0, '0, 32'd0, 32'd0);
    send_item(OP_DAY, '0, '0, '0, '0, '0);
    send_item(OP_START, '0, '0, '0, ONE, ONE / 100);
    for (int d = 0; d < 8; d++) send_item(OP_DAY, '0, '0, '0, '0, '0);
    drain();

    for (int p = 0; p < 5; p++) begin
      steady = (p == 1);
      case (p)
        0: write_all(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        1: write_all(32'd0, ONE, ONE, ONE, ONE, 32'd1, 32'hFFFF_FFFF, 32'd255);
        2: write_all(32'h0800_0000, ONE / 5, ONE / 2, ONE / 2, ONE, 32'hFFFF, ONE / 2,
                     32'd2);
        default: write_all($urandom_range(0, 32'h4000_0000), $urandom_range(0, ONE / 2),
                           rand_frac(), rand_frac(), rand_frac(), $urandom_range(1, 40),
                           $urandom(), $urandom_range(0, 12));
      endcase
      send_item(OP_START, '0, '0, '0, $urandom_range(ONE / 2, ONE),
                $urandom_range(1, ONE / 64));
      for (int n = 0; n < PHASE_ITEMS; n++) random_item();
      drain();
    end

    if (fail_count == 0 && backlog == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
